FILE: hw/rtl/triangle_circumcenter_macros.svh
// Assertion macros shared by the circumcenter block.
`ifndef TRIANGLE_CIRCUMCENTER_MACROS_SVH
`define TRIANGLE_CIRCUMCENTER_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds, outside reset.
`define TC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("triangle_circumcenter check failed");

// Checks that cons holds in the cycle after ante, outside reset.
`define TC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("triangle_circumcenter sequence check failed");

`endif

FILE: hw/rtl/tc_pkg.sv
// Types and constants of the circumcenter pipeline.
package tc_pkg;

  // Quotient bits produced by the divider: 32 result bits plus one guard bit.
  localparam int QW = 33;

  typedef struct packed {
    logic vld;
    logic neg_x;
    logic neg_y;
    logic degen;
    logic ovf_x;
    logic ovf_y;
  } tc_ctl_t;

endpackage

FILE: hw/rtl/triangle_circumcenter.sv
// Pipelined circumcenter of a 2D triangle in signed fixed point.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// The divider is a restoring one, one quotient bit per stage over 33 stages.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
`include "triangle_circumcenter_macros.svh"
module triangle_circumcenter
  import tc_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by_coord,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_center_x,
  output logic signed [31:0]            out_center_y,
  output logic                          out_degenerate,
  output logic                          out_saturated
);

  // The fraction width does not change the arithmetic: a cubic over a quadratic of
  // Q codes is again a Q code. It is kept to document the format of the ports.
  localparam int W    = COORD_WIDTH + 0 * FRAC_BITS;
  localparam int DW   = W + 1;         // coordinate differences
  localparam int SW   = 2 * W;         // squared distance from origin
  localparam int PW   = 2 * W + 2;     // partial products of numerators
  localparam int AW   = 2 * W + 1;     // area products
  localparam int NW   = 3 * W + 3;     // numerators
  localparam int DENW = 2 * W + 4;     // twice the signed area
  localparam int XW   = NW + QW + 1;   // divider working width

  // A single enable moves every stage; nothing moves while a result waits.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    logic signed [W-1:0] n;
    n = -v;
    return v[W-1] ? n : v;
  endfunction

  // Stage 1: squares of the corner magnitudes and coordinate differences.
  logic               v1_r;
  logic [SW-1:0]      sq_x1_r, sq_y1_r, sq_x2_r, sq_y2_r, sq_x3_r, sq_y3_r;
  logic signed [DW-1:0] dy23_1_r, dy31_1_r, dy12_1_r, dx32_1_r, dx13_1_r, dx21_1_r;
  logic signed [W-1:0]  x1_1_r, x2_1_r, x3_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      sq_x1_r  <= SW'(mag(in_ax)) * SW'(mag(in_ax));
      sq_y1_r  <= SW'(mag(in_ay)) * SW'(mag(in_ay));
      sq_x2_r  <= SW'(mag(in_bx)) * SW'(mag(in_bx));
      sq_y2_r  <= SW'(mag(in_by_coord)) * SW'(mag(in_by_coord));
      sq_x3_r  <= SW'(mag(in_cx)) * SW'(mag(in_cx));
      sq_y3_r  <= SW'(mag(in_cy)) * SW'(mag(in_cy));
      dy23_1_r <= DW'(in_by_coord) - DW'(in_cy);
      dy31_1_r <= DW'(in_cy) - DW'(in_ay);
      dy12_1_r <= DW'(in_ay) - DW'(in_by_coord);
      dx32_1_r <= DW'(in_cx) - DW'(in_bx);
      dx13_1_r <= DW'(in_ax) - DW'(in_cx);
      dx21_1_r <= DW'(in_bx) - DW'(in_ax);
      x1_1_r   <= in_ax;
      x2_1_r   <= in_bx;
      x3_1_r   <= in_cx;
    end
  end

  // Stage 2: squared distances.
  logic               v2_r;
  logic [SW-1:0]      s1_r, s2_r, s3_r;
  logic signed [DW-1:0] dy23_2_r, dy31_2_r, dy12_2_r, dx32_2_r, dx13_2_r, dx21_2_r;
  logic signed [W-1:0]  x1_2_r, x2_2_r, x3_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      s1_r     <= sq_x1_r + sq_y1_r;
      s2_r     <= sq_x2_r + sq_y2_r;
      s3_r     <= sq_x3_r + sq_y3_r;
      dy23_2_r <= dy23_1_r;
      dy31_2_r <= dy31_1_r;
      dy12_2_r <= dy12_1_r;
      dx32_2_r <= dx32_1_r;
      dx13_2_r <= dx13_1_r;
      dx21_2_r <= dx21_1_r;
      x1_2_r   <= x1_1_r;
      x2_2_r   <= x2_1_r;
      x3_2_r   <= x3_1_r;
    end
  end

  // Stage 3: each squared distance is split in halves so that every product
  // stays near W by W bits.
  logic               v3_r;
  logic signed [PW-1:0] px_lo_r [0:2];
  logic signed [PW-1:0] px_hi_r [0:2];
  logic signed [PW-1:0] py_lo_r [0:2];
  logic signed [PW-1:0] py_hi_r [0:2];
  logic signed [AW-1:0] pa_r    [0:2];

  function automatic logic signed [PW-1:0] pmul(input logic [W-1:0] s,
                                                input logic signed [DW-1:0] d);
    logic signed [W:0] sx;
    sx = $signed({1'b0, s});
    return PW'(sx) * PW'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      px_lo_r[0] <= pmul(s1_r[W-1:0], dy23_2_r);
      px_hi_r[0] <= pmul(s1_r[SW-1:W], dy23_2_r);
      px_lo_r[1] <= pmul(s2_r[W-1:0], dy31_2_r);
      px_hi_r[1] <= pmul(s2_r[SW-1:W], dy31_2_r);
      px_lo_r[2] <= pmul(s3_r[W-1:0], dy12_2_r);
      px_hi_r[2] <= pmul(s3_r[SW-1:W], dy12_2_r);
      py_lo_r[0] <= pmul(s1_r[W-1:0], dx32_2_r);
      py_hi_r[0] <= pmul(s1_r[SW-1:W], dx32_2_r);
      py_lo_r[1] <= pmul(s2_r[W-1:0], dx13_2_r);
      py_hi_r[1] <= pmul(s2_r[SW-1:W], dx13_2_r);
      py_lo_r[2] <= pmul(s3_r[W-1:0], dx21_2_r);
      py_hi_r[2] <= pmul(s3_r[SW-1:W], dx21_2_r);
      pa_r[0]    <= AW'(x1_2_r) * AW'(dy23_2_r);
      pa_r[1]    <= AW'(x2_2_r) * AW'(dy31_2_r);
      pa_r[2]    <= AW'(x3_2_r) * AW'(dy12_2_r);
    end
  end

  // Stage 4: numerators and twice the area.
  logic               v4_r;
  logic signed [NW-1:0]   num_x_r, num_y_r;
  logic signed [DENW-1:0] den_r;
  logic signed [NW-1:0]   num_x_nxt, num_y_nxt;
  logic signed [DENW-1:0] area_nxt;

  always_comb begin
    num_x_nxt = '0;
    num_y_nxt = '0;
    area_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      num_x_nxt = num_x_nxt + (NW'(px_hi_r[i]) <<< W) + NW'(px_lo_r[i]);
      num_y_nxt = num_y_nxt + (NW'(py_hi_r[i]) <<< W) + NW'(py_lo_r[i]);
      area_nxt  = area_nxt + DENW'(pa_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      num_x_r <= num_x_nxt;
      num_y_r <= num_y_nxt;
      den_r   <= area_nxt <<< 1;
    end
  end

  // Stage 5: magnitudes and quotient signs.
  logic            v5_r;
  logic [NW-1:0]   nmx_r, nmy_r;
  logic [DENW-1:0] dm_r;
  logic            negx5_r, negy5_r, degen5_r;
  logic signed [NW-1:0]   num_x_neg, num_y_neg;
  logic signed [DENW-1:0] den_neg;

  assign num_x_neg = -num_x_r;
  assign num_y_neg = -num_y_r;
  assign den_neg   = -den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      nmx_r    <= num_x_r[NW-1] ? num_x_neg : num_x_r;
      nmy_r    <= num_y_r[NW-1] ? num_y_neg : num_y_r;
      dm_r     <= den_r[DENW-1] ? den_neg : den_r;
      negx5_r  <= num_x_r[NW-1] ^ den_r[DENW-1];
      negy5_r  <= num_y_r[NW-1] ^ den_r[DENW-1];
      degen5_r <= (den_r == '0);
    end
  end

  // Divider: entry 0 holds the overflow test; each later entry settles one
  // quotient bit, most significant first.
  logic [XW-1:0]   rx_r [0:QW];
  logic [XW-1:0]   ry_r [0:QW];
  logic [DENW-1:0] dv_r [0:QW];
  logic [QW-1:0]   qx_r [0:QW];
  logic [QW-1:0]   qy_r [0:QW];
  tc_ctl_t         ctl_r [0:QW];
  tc_ctl_t         ctl0_nxt;
  logic [XW-1:0]   dtop;

  assign dtop = XW'(dm_r) << QW;

  always_comb begin
    ctl0_nxt       = '0;
    ctl0_nxt.vld   = v5_r;
    ctl0_nxt.neg_x = negx5_r;
    ctl0_nxt.neg_y = negy5_r;
    ctl0_nxt.degen = degen5_r;
    ctl0_nxt.ovf_x = XW'(nmx_r) >= dtop;
    ctl0_nxt.ovf_y = XW'(nmy_r) >= dtop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl0_nxt;
    end
    if (en) begin
      rx_r[0] <= XW'(nmx_r);
      ry_r[0] <= XW'(nmy_r);
      dv_r[0] <= dm_r;
      qx_r[0] <= '0;
      qy_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rx_nxt, ry_nxt;
    logic [QW-1:0] qx_nxt, qy_nxt;

    assign dsh = XW'(dv_r[k]) << SH;

    always_comb begin
      rx_nxt = rx_r[k];
      ry_nxt = ry_r[k];
      qx_nxt = qx_r[k];
      qy_nxt = qy_r[k];
      if (rx_r[k] >= dsh) begin
        rx_nxt     = rx_r[k] - dsh;
        qx_nxt[SH] = 1'b1;
      end
      if (ry_r[k] >= dsh) begin
        ry_nxt     = ry_r[k] - dsh;
        qy_nxt[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
      if (en) begin
        rx_r[k+1] <= rx_nxt;
        ry_r[k+1] <= ry_nxt;
        qx_r[k+1] <= qx_nxt;
        qy_r[k+1] <= qy_nxt;
        dv_r[k+1] <= dv_r[k];
      end
    end
  end

  // Output stage: sign, clamp to 32 bits, and the degenerate override.
  // Returns the saturation flag above the 32-bit value.
  function automatic logic [32:0] finish(input logic [QW-1:0] q, input logic neg,
                                         input logic ovf);
    logic        sat;
    logic [31:0] val;
    sat = 1'b0;
    val = q[31:0];
    if (ovf) begin
      sat = 1'b1;
      val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (q == '0) begin
      val = '0;
    end else if (!neg) begin
      if (q > QW'(32'h7FFF_FFFF)) begin
        sat = 1'b1;
        val = 32'h7FFF_FFFF;
      end
    end else begin
      if (q > QW'(33'h0_8000_0000)) begin
        sat = 1'b1;
        val = 32'h8000_0000;
      end else begin
        val = -q[31:0];
      end
    end
    return {sat, val};
  endfunction

  logic [32:0] fx, fy;
  tc_ctl_t     cf;

  assign cf = ctl_r[QW];
  assign fx = finish(qx_r[QW], cf.neg_x, cf.ovf_x);
  assign fy = finish(qy_r[QW], cf.neg_y, cf.ovf_y);

  logic               out_valid_r;
  logic signed [31:0] out_center_x_r, out_center_y_r;
  logic               out_degenerate_r, out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cf.vld;
    end
    if (en) begin
      out_degenerate_r <= cf.degen;
      if (cf.degen) begin
        out_center_x_r  <= '0;
        out_center_y_r  <= '0;
        out_saturated_r <= 1'b0;
      end else begin
        out_center_x_r  <= fx[31:0];
        out_center_y_r  <= fy[31:0];
        out_saturated_r <= fx[32] | fy[32];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center_x   = out_center_x_r;
  assign out_center_y   = out_center_y_r;
  assign out_degenerate = out_degenerate_r;
  assign out_saturated  = out_saturated_r;

  // A degenerate triangle always reports a zero center without saturation.
  `TC_ASSERT_SAME(a_degen_zero, out_valid && out_degenerate,
                  out_center_x == 0 && out_center_y == 0 && !out_saturated)
  // The input side is held exactly when a result is waiting to be taken.
  `TC_ASSERT_SAME(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))
  // A word that leaves the divider with a zero divisor is flagged degenerate.
  `TC_ASSERT_NEXT(a_degen_flag, en && cf.vld && dv_r[QW] == '0,
                  out_valid && out_degenerate)

endmodule
